@@ sv/long_reply_frame_parser_assert.svh @@
// assertion macros shared by the frame parser rtl
`ifndef LONG_REPLY_FRAME_PARSER_ASSERT_SVH
`define LONG_REPLY_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define LRFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// next-cycle implication
`define LRFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

@@ sv/lrfp_pkg.sv @@
// package: shared types and constants of the long reply frame parser
`timescale 1ns / 1ps
`default_nettype none

package lrfp_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 64;
  localparam int unsigned FRAME_BYTES      = 16;
  // window offset 0 leaves the window on every shift and is never read
  localparam int unsigned CELLS            = FRAME_BYTES - 1;
  localparam int unsigned CFG_IDX_W        = 1;

  localparam logic [7:0] FRAME_MARK = 8'hFE;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_BAD_SUM  = 2'd2,
    ST_NO_REPLY = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ADDRESS   = 1'd0,
    REG_EXPECTED_COMMAND = 1'd1
  } cfg_reg_t;

  // controls from the top level to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/lrfp_rx_if.sv @@
// interface: received byte channel
`timescale 1ns / 1ps
`default_nettype none

interface lrfp_rx_if;
  import lrfp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;
  logic  end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

@@ sv/lrfp_result_if.sv @@
// interface: parse result channel
`timescale 1ns / 1ps
`default_nettype none

interface lrfp_result_if;
  import lrfp_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] mode;
  byte_t      flags_byte;
  byte_t      aux_byte;
  word_t      min_value;
  word_t      max_value;
  word_t      present_value;

  modport source (output valid, output status, output mode, output flags_byte,
                  output aux_byte, output min_value, output max_value,
                  output present_value, input ready);
  modport sink   (input valid, input status, input mode, input flags_byte,
                  input aux_byte, input min_value, input max_value,
                  input present_value, output ready);
endinterface

`default_nettype wire

@@ sv/lrfp_cfg_if.sv @@
// interface: configuration register write channel
`timescale 1ns / 1ps
`default_nettype none

interface lrfp_cfg_if;
  import lrfp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  byte_t                data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/lrfp_cell.sv @@
// module: one byte cell of the sliding window chain
`timescale 1ns / 1ps
`default_nettype none

module lrfp_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lrfp_pkg::cell_ctrl_t ctrl,
  input  wire lrfp_pkg::byte_t    d,
  output lrfp_pkg::byte_t         q
);
  import lrfp_pkg::*;

  byte_t data;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      data <= '0;
    end else if (ctrl.shift) begin
      data <= d;
    end
  end

  assign q = data;
endmodule

`default_nettype wire

@@ sv/long_reply_frame_parser.sv @@
// top level: long reply frame parser with a chain of window cells
//
// usage
// - rx: one buffer byte per transfer; end_of_buffer marks the last byte,
//   which is the reply-present marker and is not entered into the window
// - result: exactly one transfer per buffer, carrying the outcome of the
//   first in-range window starting with 0xfe, the address and the command
// - cfg: device_address (index 0) and expected_command (index 1), written
//   while the block is idle; always ready
// - throughput: one byte per cycle; each byte is checked in the cycle it
//   is accepted, against a running window sum kept next to the cell chain
// - latency: the result is valid in the cycle after the end byte transfer
// - a result that is not taken holds the output register and drops rx
//   ready; non-end bytes flow whenever the output register is free
// - reset clears the window, position, decision and output valid and sets
//   device_address to 1 and expected_command to 0; after each end byte the
//   buffer state returns to its reset value, registers are kept
`timescale 1ns / 1ps
`default_nettype none
`include "long_reply_frame_parser_assert.svh"

module long_reply_frame_parser #(
  parameter int unsigned BUFFER_BYTES = lrfp_pkg::BUFFER_BYTES_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  lrfp_rx_if.sink     rx,
  lrfp_result_if.source result,
  lrfp_cfg_if.sink    cfg
);
  import lrfp_pkg::*;

  // position counts up to and saturates at BUFFER_BYTES
  localparam int unsigned POS_W = $clog2(BUFFER_BYTES + 1);

  // configuration registers
  byte_t device_address;
  byte_t expected_command;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address   <= 8'd1;
      expected_command <= 8'd0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_DEVICE_ADDRESS:   device_address   <= cfg.data;
        REG_EXPECTED_COMMAND: expected_command <= cfg.data;
        default: ;
      endcase
    end
  end

  // handshake
  logic rx_take;
  logic take_byte;
  logic take_end;

  assign rx.ready  = !result.valid || result.ready;
  assign rx_take   = rx.valid && rx.ready;
  assign take_byte = rx_take && !rx.end_of_buffer;
  assign take_end  = rx_take && rx.end_of_buffer;

  // window cells: cell k holds offset k+1 of the current window, which is
  // offset k of the window formed once the incoming byte is shifted in
  cell_ctrl_t ctrl;
  byte_t      cell_q [CELLS];

  assign ctrl.shift = take_byte;
  assign ctrl.clear = take_end;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    byte_t cell_d;
    if (k == CELLS - 1) begin : g_last
      assign cell_d = rx.rx_byte;
    end else begin : g_mid
      assign cell_d = cell_q[k+1];
    end
    lrfp_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .d    (cell_d),
      .q    (cell_q[k])
    );
  end

  // running sum of all cells, i.e. offsets 0..14 of the next window;
  // one byte leaves at the head of the chain, one enters at its tail
  byte_t win_sum;

  always_ff @(posedge clk) begin
    if (rst || take_end) begin
      win_sum <= '0;
    end else if (take_byte) begin
      win_sum <= win_sum - cell_q[0] + rx.rx_byte;
    end
  end

  // buffer position and scan decision
  logic [POS_W-1:0] pos;
  logic             decided;
  status_t          held_status;
  logic [63:0]      held_fields;
  logic             in_range;
  logic             header_hit;
  logic             sum_good;
  logic             check;

  // the window formed by this byte starts at buffer byte pos-15
  assign in_range   = (pos >= POS_W'(FRAME_BYTES)) && (pos <= POS_W'(BUFFER_BYTES - 2));
  assign header_hit = (cell_q[0] == FRAME_MARK) && (cell_q[1] == device_address) &&
                      (cell_q[2] == expected_command);
  assign sum_good   = (byte_t'(win_sum - (device_address - 8'd1)) == rx.rx_byte);
  assign check      = take_byte && !decided && in_range && header_hit;

  always_ff @(posedge clk) begin
    if (rst || take_end) begin
      pos         <= '0;
      decided     <= 1'b0;
      held_status <= ST_NO_FRAME;
    end else if (take_byte) begin
      if (pos < POS_W'(BUFFER_BYTES)) begin
        pos <= pos + POS_W'(1);
      end
      if (check) begin
        decided     <= 1'b1;
        held_status <= sum_good ? ST_OK : ST_BAD_SUM;
      end
    end
  end

  // frame offsets 7..14 of the next window, masked by status on output
  always_ff @(posedge clk) begin
    if (check && sum_good) begin
      held_fields <= {cell_q[7], cell_q[8], cell_q[9], cell_q[10],
                      cell_q[11], cell_q[12], cell_q[13], cell_q[14]};
    end
  end

  // output register
  status_t     out_status;
  logic [63:0] out_fields;

  assign out_status = (rx.rx_byte == 8'd0) ? ST_NO_REPLY : held_status;
  assign out_fields = (out_status == ST_OK) ? held_fields : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take_end) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_end) begin
      result.status        <= out_status;
      result.mode          <= out_fields[57:56];
      result.flags_byte    <= out_fields[63:56];
      result.aux_byte      <= out_fields[55:48];
      result.min_value     <= out_fields[47:32];
      result.max_value     <= out_fields[31:16];
      result.present_value <= out_fields[15:0];
    end
  end

  // checks
  `LRFP_ASSERT_NEXT(a_clear_after_end, take_end, (pos == '0) && !decided && result.valid)
  `LRFP_ASSERT_NOW(a_open_status, !decided, held_status == ST_NO_FRAME)
  `LRFP_ASSERT_NOW(a_decided_status, decided,
                   (held_status == ST_OK) || (held_status == ST_BAD_SUM))
  `LRFP_ASSERT_NOW(a_stall_blocks_rx, result.valid && !result.ready, !rx.ready)
  `LRFP_ASSERT_NOW(a_pos_bound, 1'b1, pos <= POS_W'(BUFFER_BYTES))
endmodule

`default_nettype wire

@@ verif/long_reply_frame_parser_tb.sv @@
// testbench: long reply frame parser, self-checking against a scan predictor
`timescale 1ns / 1ps

module long_reply_frame_parser_tb;
  import lrfp_pkg::*;

  localparam int unsigned BUF_BYTES = BUFFER_BYTES_DEF;
  // cycles with no transfer on any channel before the run is abandoned;
  // well above the long receiver hold-off and the longest random gaps
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef enum int {PAY_RANDOM, PAY_ONES, PAY_ZEROS} payload_kind_t;

  // one parse result as it leaves the block
  typedef struct packed {
    status_t    status;
    logic [1:0] mode;
    byte_t      flags_byte;
    byte_t      aux_byte;
    word_t      min_value;
    word_t      max_value;
    word_t      present_value;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst;

  lrfp_rx_if     rx_ch ();
  lrfp_result_if res_ch ();
  lrfp_cfg_if    cfg_ch ();

  long_reply_frame_parser #(.BUFFER_BYTES(BUF_BYTES)) dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // predictor state: register copies plus the scan of the current buffer
  // ---------------------------------------------------------------------
  byte_t      cfg_address;
  byte_t      cfg_command;
  byte_t      scan_window [FRAME_BYTES];
  int         scan_pos;
  bit         scan_decided;
  status_t    found_status;
  logic [63:0] found_fields;

  parse_result_t expected_results[$];
  byte_t         pending_bytes[$];   // buffer under construction

  int mismatch_count = 0;
  int bytes_sent = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;

  // buffer state back to its idle value, registers untouched
  function automatic void clear_scan();
    foreach (scan_window[k]) scan_window[k] = '0;
    scan_pos = 0;
    scan_decided = 1'b0;
    found_status = ST_NO_FRAME;
    found_fields = '0;
  endfunction

  // advance the predictor by one accepted rx transfer
  function automatic void track_rx_byte(input byte_t value, input bit last);
    byte_t         sum;
    status_t       st;
    logic [63:0]   f;
    parse_result_t r;
    if (!last) begin
      for (int k = 0; k < FRAME_BYTES - 1; k++) scan_window[k] = scan_window[k + 1];
      scan_window[FRAME_BYTES - 1] = value;
      // window holds buffer bytes scan_pos-15 .. scan_pos; starts 1 .. BUF_BYTES-17
      if (!scan_decided && scan_pos >= FRAME_BYTES && scan_pos <= BUF_BYTES - 2 &&
          scan_window[0] == FRAME_MARK && scan_window[1] == cfg_address &&
          scan_window[2] == cfg_command) begin
        sum = '0;
        for (int k = 0; k < FRAME_BYTES - 1; k++) sum = sum + scan_window[k];
        sum = sum - (cfg_address - 8'd1);
        scan_decided = 1'b1;
        if (sum == scan_window[FRAME_BYTES - 1]) begin
          found_status = ST_OK;
          for (int k = 7; k < 15; k++) found_fields = {found_fields[55:0], scan_window[k]};
        end else begin
          found_status = ST_BAD_SUM;
        end
      end
      if (scan_pos < BUF_BYTES) scan_pos++;
    end else begin
      // the end byte is the reply marker and never enters the window
      st = found_status;
      if (value == 8'h00) st = ST_NO_REPLY;
      f = (st == ST_OK) ? found_fields : '0;
      r.status        = st;
      r.mode          = f[57:56];
      r.flags_byte    = f[63:56];
      r.aux_byte      = f[55:48];
      r.min_value     = f[47:32];
      r.max_value     = f[31:16];
      r.present_value = f[15:0];
      expected_results.push_back(r);
      clear_scan();
    end
  endfunction

  // ---------------------------------------------------------------------
  // result side: ready pattern, long hold-off on request, and checking
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_request = 1'b0;
    end
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      // receiver refuses everything so the block backs up into rx
      res_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    parse_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result transfer with none expected, status %0d", $time,
                 res_ch.status);
      end else begin
        want = expected_results.pop_front();
        check_field("status", 16'(want.status), 16'(res_ch.status));
        check_field("mode", 16'(want.mode), 16'(res_ch.mode));
        check_field("flags_byte", 16'(want.flags_byte), 16'(res_ch.flags_byte));
        check_field("aux_byte", 16'(want.aux_byte), 16'(res_ch.aux_byte));
        check_field("min_value", want.min_value, res_ch.min_value);
        check_field("max_value", want.max_value, res_ch.max_value);
        check_field("present_value", want.present_value, res_ch.present_value);
      end
    end
  end

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // rx side: one byte per transfer, random gaps before each offer
  // ---------------------------------------------------------------------
  task automatic send_byte(input byte_t value, input bit last);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid         <= 1'b1;
    rx_ch.rx_byte       <= value;
    rx_ch.end_of_buffer <= last;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    track_rx_byte(value, last);
    bytes_sent++;
  endtask

  // send the built-up buffer followed by its reply marker
  task automatic send_buffer(input byte_t marker);
    foreach (pending_bytes[i]) send_byte(pending_bytes[i], 1'b0);
    send_byte(marker, 1'b1);
    pending_bytes.delete();
  endtask

  // filler leans toward the frame mark so false starts turn up
  task automatic push_filler(input int count);
    for (int i = 0; i < count; i++)
      pending_bytes.push_back(($urandom_range(7) == 0) ? FRAME_MARK :
                              byte_t'($urandom_range(255)));
  endtask

  task automatic push_frame(input byte_t addr, input byte_t cmd, input bit good_sum,
                            input payload_kind_t fill);
    byte_t frame [FRAME_BYTES];
    byte_t sum;
    frame[0] = FRAME_MARK;
    frame[1] = addr;
    frame[2] = cmd;
    for (int k = 3; k < FRAME_BYTES - 1; k++)
      frame[k] = (fill == PAY_ONES)  ? 8'hFF :
                 (fill == PAY_ZEROS) ? 8'h00 : byte_t'($urandom_range(255));
    sum = '0;
    for (int k = 0; k < FRAME_BYTES - 1; k++) sum = sum + frame[k];
    sum = sum - (addr - 8'd1);
    frame[FRAME_BYTES - 1] = good_sum ? sum : (sum ^ byte_t'($urandom_range(1, 255)));
    foreach (frame[k]) pending_bytes.push_back(frame[k]);
  endtask

  // drop rx valid, let every expected result arrive, then a few quiet cycles
  task automatic wait_until_drained();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers, only with the block idle
  task automatic write_config(input byte_t addr, input byte_t cmd);
    wait_until_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_DEVICE_ADDRESS;
    cfg_ch.data  <= addr;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_address = addr;
    cfg_ch.index <= REG_EXPECTED_COMMAND;
    cfg_ch.data  <= cmd;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_command = cmd;
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // reply marker handling with the reset register values
  task automatic test_reply_markers();
    // empty buffers: zero marker means no reply, nonzero means no frame
    send_buffer(8'h00);
    send_buffer(8'hFF);
    // good frame at the first scanned start, all-ones payload
    push_filler(1);
    push_frame(cfg_address, cfg_command, 1'b1, PAY_ONES);
    send_buffer(8'h01);
    // same frame, zero marker overrides the match
    push_filler(1);
    push_frame(cfg_address, cfg_command, 1'b1, PAY_ONES);
    send_buffer(8'h00);
  endtask

  // which window starts get scanned
  task automatic test_frame_positions();
    // frame at buffer byte 0 is never a window start
    push_frame(cfg_address, cfg_command, 1'b1, PAY_RANDOM);
    send_buffer(8'h5A);
    // last scanned start
    push_filler(BUF_BYTES - 17);
    push_frame(cfg_address, cfg_command, 1'b1, PAY_RANDOM);
    send_buffer(8'hA5);
    // one past the last scanned start
    push_filler(BUF_BYTES - 16);
    push_frame(cfg_address, cfg_command, 1'b1, PAY_RANDOM);
    send_buffer(8'h80);
    // checksum byte arrives as the end byte, so the window never completes
    push_filler(1);
    push_frame(cfg_address, cfg_command, 1'b1, PAY_RANDOM);
    send_buffer(pending_bytes.pop_back());
    // early end in the middle of a frame
    push_filler(3);
    push_frame(cfg_address, cfg_command, 1'b1, PAY_RANDOM);
    repeat (8) pending_bytes.delete(pending_bytes.size() - 1);
    send_buffer(8'h7F);
  endtask

  // the first matching window decides, later ones are ignored
  task automatic test_first_window_decides();
    push_filler(2);
    push_frame(cfg_address, cfg_command, 1'b0, PAY_RANDOM);
    push_frame(cfg_address, cfg_command, 1'b1, PAY_RANDOM);
    send_buffer(8'h11);
    push_filler(2);
    push_frame(cfg_address, cfg_command, 1'b1, PAY_RANDOM);
    push_frame(cfg_address, cfg_command, 1'b0, PAY_RANDOM);
    send_buffer(8'h22);
    // wrong command in front of a good frame does not decide anything
    push_filler(1);
    push_frame(cfg_address, cfg_command + 8'd1, 1'b1, PAY_RANDOM);
    push_frame(cfg_address, cfg_command, 1'b1, PAY_RANDOM);
    send_buffer(8'h33);
  endtask

  // buffers past BUFFER_BYTES without an end flag
  task automatic test_long_buffers();
    // early frame, long tail while the position saturates
    push_filler(5);
    push_frame(cfg_address, cfg_command, 1'b1, PAY_RANDOM);
    push_filler(90);
    send_buffer(8'h44);
    // frame only beyond the scanned range
    push_filler(70);
    push_frame(cfg_address, cfg_command, 1'b1, PAY_RANDOM);
    send_buffer(8'h55);
  endtask

  // register extremes, including the address that wraps the checksum offset
  task automatic test_register_extremes();
    write_config(8'h00, 8'hFF);
    push_filler(1);
    push_frame(cfg_address, cfg_command, 1'b1, PAY_ZEROS);
    send_buffer(8'h01);
    // frame for the reset address no longer matches
    push_filler(1);
    push_frame(8'h01, 8'h00, 1'b1, PAY_RANDOM);
    send_buffer(8'h02);
    write_config(8'hFF, 8'h00);
    push_filler(1);
    push_frame(cfg_address, cfg_command, 1'b1, PAY_ONES);
    send_buffer(8'h03);
    write_config(8'h80, 8'h7F);
    push_filler(4);
    push_frame(cfg_address, cfg_command, 1'b0, PAY_RANDOM);
    send_buffer(8'h04);
  endtask

  // receiver holds off for a long stretch while rx keeps offering buffers
  task automatic test_backpressure();
    wait_until_drained();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_request = 1'b1;
    repeat (4) begin
      push_filler(1);
      push_frame(cfg_address, cfg_command, 1'b1, PAY_RANDOM);
      send_buffer(byte_t'($urandom_range(1, 255)));
    end
  endtask

  // one random buffer: mostly well-formed frames, the rest broken or noise
  task automatic send_random_buffer();
    int    kind;
    int    lead;
    int    tail;
    byte_t marker;
    kind = $urandom_range(99);
    lead = $urandom_range(0, BUF_BYTES - 17);
    tail = $urandom_range(0, 8);
    if ($urandom_range(19) == 0) tail += $urandom_range(20, 50);
    marker = ($urandom_range(9) == 0) ? 8'h00 : byte_t'($urandom_range(1, 255));
    push_filler(lead);
    if (kind < 60) begin
      push_frame(cfg_address, cfg_command, $urandom_range(4) != 0, PAY_RANDOM);
    end else if (kind < 70) begin
      // two candidate frames back to back
      push_frame(cfg_address, cfg_command, $urandom_range(1) != 0, PAY_RANDOM);
      push_frame(cfg_address, cfg_command, 1'b1, PAY_RANDOM);
    end else if (kind < 80) begin
      // truncated frame
      push_frame(cfg_address, cfg_command, 1'b1, PAY_RANDOM);
      repeat ($urandom_range(1, 15)) pending_bytes.delete(pending_bytes.size() - 1);
    end else if (kind < 88) begin
      // address or command off by a random nonzero pattern
      if ($urandom_range(1) != 0)
        push_frame(cfg_address ^ byte_t'($urandom_range(1, 255)), cfg_command, 1'b1,
                   PAY_RANDOM);
      else
        push_frame(cfg_address, cfg_command ^ byte_t'($urandom_range(1, 255)), 1'b1,
                   PAY_RANDOM);
    end else begin
      push_filler($urandom_range(0, 30));
    end
    push_filler(tail);
    send_buffer(marker);
  endtask

  // traffic phases, each with its own register setting and rx idle and stall rates
  task automatic test_random_traffic();
    int byte_goal;
    int buffer_count;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_config(byte_t'($urandom_range(255)), 8'hFF);
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          write_config(8'h00, byte_t'($urandom_range(255)));
          src_idle_pct = 86;
          sink_stall_pct = 0;
        end
        2: begin
          write_config(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)));
          src_idle_pct = 0;
          sink_stall_pct = 86;
        end
        default: begin
          // back to the reset values
          write_config(8'h01, 8'h00);
          src_idle_pct = 6;
          sink_stall_pct = 6;
        end
      endcase
      byte_goal = bytes_sent + 280;
      buffer_count = 0;
      while (bytes_sent < byte_goal || buffer_count < 4) begin
        send_random_buffer();
        buffer_count++;
      end
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    rx_ch.valid         <= 1'b0;
    rx_ch.rx_byte       <= '0;
    rx_ch.end_of_buffer <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_DEVICE_ADDRESS;
    cfg_ch.data         <= '0;
    cfg_address = 8'h01;
    cfg_command = 8'h00;
    clear_scan();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reply_markers();
    test_frame_positions();
    test_first_window_decides();
    test_long_buffers();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();

    wait_until_drained();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
